### rtl/core/tlik_pkg.sv
`default_nettype none

package tlik_pkg;

   // field and datapath widths
   localparam int COORD_WIDTH = 16;
   localparam int LEN_WIDTH   = 15;
   localparam int ANGLE_WIDTH = 16;
   localparam int ELBOW_WIDTH = 14;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int D2_WIDTH    = 34;
   localparam int NUM_WIDTH   = 36;
   localparam int DIST_WIDTH  = 16;
   localparam int DEN_WIDTH   = 32;
   localparam int REM_WIDTH   = 48;
   localparam int QUO_WIDTH   = 16;
   localparam int MAG_WIDTH   = 15;
   localparam int ROOT1_WIDTH = 32;
   localparam int ROOT2_WIDTH = 30;
   localparam int CW          = 41;
   localparam int ZW          = 32;

   localparam int ONE_Q14     = 16384;
   localparam int PI_Q12      = 12868;
   localparam int HALF_PI_Q28 = 421657428;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_REACH = 2'd1,
      ST_ZERO  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_BASE_X    = 2'd0,
      REG_BASE_Y    = 2'd1,
      REG_UPPER_LEN = 2'd2,
      REG_LOWER_LEN = 2'd3
   } csr_index_type;

   // vector under rotation plus its angle accumulator (Q3.28)
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } vec_type;

   localparam int ATAN_Q28 [32] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
      2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0
   };

endpackage

`default_nettype wire

### rtl/core/tlik_delay.sv
`default_nettype none

module tlik_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] data_i,
   output logic      [WIDTH-1:0] data_o
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= data_i;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign data_o = line_ff[DEPTH-1];

endmodule

`default_nettype wire

### rtl/core/tlik_sqrt_cell.sv
`default_nettype none

module tlik_sqrt_cell #(
   parameter int WIDTH = 32,
   parameter int K     = 0
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] rem_i,
   input  wire logic [WIDTH-1:0] root_i,
   output logic      [WIDTH-1:0] rem_o,
   output logic      [WIDTH-1:0] root_o
);

   localparam logic [WIDTH-1:0] BIT = WIDTH'(1) << (2 * K);

   logic [WIDTH:0]   trial;
   logic [WIDTH-1:0] rem_ff, rem_in, root_ff, root_in;

   // one result bit: try to take off root + bit
   always_comb begin
      trial = {1'b0, root_i} + {1'b0, BIT};
      if ({1'b0, rem_i} >= trial) begin
         rem_in  = rem_i - trial[WIDTH-1:0];
         root_in = (root_i >> 1) + BIT;
      end else begin
         rem_in  = rem_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

`default_nettype wire

### rtl/core/tlik_div_cell.sv
`default_nettype none

module tlik_div_cell #(
   parameter int K = 0
) (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic [tlik_pkg::REM_WIDTH-1:0] rem_i,
   input  wire logic [tlik_pkg::DEN_WIDTH-1:0] den_i,
   input  wire logic [tlik_pkg::QUO_WIDTH-1:0] quo_i,
   output logic      [tlik_pkg::REM_WIDTH-1:0] rem_o,
   output logic      [tlik_pkg::DEN_WIDTH-1:0] den_o,
   output logic      [tlik_pkg::QUO_WIDTH-1:0] quo_o
);
   import tlik_pkg::*;

   logic [REM_WIDTH-1:0] shifted, rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] den_ff;
   logic [QUO_WIDTH-1:0] quo_ff, quo_in;

   // restoring step for quotient bit K
   always_comb begin
      shifted = REM_WIDTH'(den_i) << K;
      if (rem_i >= shifted) begin
         rem_in = rem_i - shifted;
         quo_in = quo_i | (QUO_WIDTH'(1) << K);
      end else begin
         rem_in = rem_i;
         quo_in = quo_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_i;
         quo_ff <= quo_in;
      end
   end

   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;

endmodule

`default_nettype wire

### rtl/core/tlik_cordic_cell.sv
`default_nettype none

module tlik_cordic_cell #(
   parameter int K = 0
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire tlik_pkg::vec_type vec_i,
   output tlik_pkg::vec_type      vec_o
);
   import tlik_pkg::*;

   localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_Q28[K]);

   vec_type vec_ff, vec_in;
   logic signed [CW-1:0] xs, ys;

   // rotate towards the x axis, steering on the sign of y
   always_comb begin
      xs = vec_i.x >>> K;
      ys = vec_i.y >>> K;
      if (vec_i.y < 0) begin
         vec_in.x = vec_i.x - ys;
         vec_in.y = vec_i.y + xs;
         vec_in.z = vec_i.z - ANGLE;
      end else begin
         vec_in.x = vec_i.x + ys;
         vec_in.y = vec_i.y - xs;
         vec_in.z = vec_i.z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign vec_o = vec_ff;

endmodule

`default_nettype wire

### rtl/core/two_link_inverse_kinematics_unit.sv
// Throughput: one target per cycle; every stage is a register, and the whole
// pipeline advances together whenever the output register is empty or taken.
// Reset (synchronous, active high) empties the pipeline and returns base to
// (0, 0) and both link lengths to 1.0; data registers are not cleared.
`default_nettype none

module two_link_inverse_kinematics_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // target_x[15:0], target_y[31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // upper_angle[15:0], elbow_angle[29:16], zero pad
   output logic      [1:0]  rsp_tuser,   // status[1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import tlik_pkg::*;

   // pipeline geometry
   localparam int SQ1_STEPS    = DIST_WIDTH;
   localparam int DIV_STEPS    = QUO_WIDTH;
   localparam int SQ2_STEPS    = ROOT2_WIDTH / 2;
   localparam int SIDE_DEPTH   = SQ1_STEPS + 2 + DIV_STEPS + 2 + SQ2_STEPS;
   localparam int STATUS_DEPTH = SIDE_DEPTH + 1 + CORDIC_STEPS;
   localparam int NUM_DEPTH    = SQ1_STEPS + 1;
   localparam int LATENCY      = 5 + SIDE_DEPTH + 1 + CORDIC_STEPS + 1;
   localparam logic [ROOT2_WIDTH-1:0] ONE_SQ = ROOT2_WIDTH'(ONE_Q14) * ROOT2_WIDTH'(ONE_Q14);

   logic en;
   logic [LATENCY-1:0] vld_ff;

   // ------------------------------------------------------------------
   // configuration registers; the port never pushes back
   // ------------------------------------------------------------------
   logic [COORD_WIDTH-1:0] base_x_ff, base_y_ff;
   logic [LEN_WIDTH-1:0]   l1_ff, l2_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= '0;
         base_y_ff <= '0;
         l1_ff     <= LEN_WIDTH'(256);
         l2_ff     <= LEN_WIDTH'(256);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_BASE_X:    base_x_ff <= csr_data;
            REG_BASE_Y:    base_y_ff <= csr_data;
            REG_UPPER_LEN: l1_ff     <= csr_data[LEN_WIDTH-1:0];
            REG_LOWER_LEN: l2_ff     <= csr_data[LEN_WIDTH-1:0];
            default:       ;
         endcase
      end
   end

   // Link-derived terms; the user must change configuration only while the pipe is empty,
   // which the block does not enforce. These are registers fed from the links and their squares.
   logic [2*LEN_WIDTH-1:0]   l1sq_ff, l2sq_ff, l1l2_ff, ldiffsq_ff;
   logic [2*LEN_WIDTH+1:0]   lsumsq_ff;
   logic [LEN_WIDTH-1:0]     ldiff;
   logic signed [2*LEN_WIDTH:0] lsub_ff;
   logic [2*LEN_WIDTH:0]     ladd_ff;
   logic                     lzero_ff;
   logic [DEN_WIDTH-1:0]     dene;

   assign ldiff = (l1_ff >= l2_ff) ? l1_ff - l2_ff : l2_ff - l1_ff;

   always_ff @(posedge clock) begin
      l1sq_ff    <= l1_ff * l1_ff;
      l2sq_ff    <= l2_ff * l2_ff;
      l1l2_ff    <= l1_ff * l2_ff;
      ldiffsq_ff <= ldiff * ldiff;
      lsumsq_ff  <= ({1'b0, l1_ff} + {1'b0, l2_ff}) * ({1'b0, l1_ff} + {1'b0, l2_ff});
      lzero_ff   <= (l1_ff == '0) || (l2_ff == '0);
      lsub_ff    <= $signed({1'b0, l1sq_ff}) - $signed({1'b0, l2sq_ff});
      ladd_ff    <= {1'b0, l1sq_ff} + {1'b0, l2sq_ff};
   end

   assign dene = {1'b0, l1l2_ff, 1'b0};

   // ------------------------------------------------------------------
   // flow control: advance everything together
   // ------------------------------------------------------------------
   assign en         = !vld_ff[LATENCY-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_tvalid};
      end
   end

   // ------------------------------------------------------------------
   // front: offset, squares, squared distance, reach test
   // ------------------------------------------------------------------
   logic [COORD_WIDTH-1:0]       tx_ff, ty_ff;
   logic signed [DIFF_WIDTH-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff, dx3_ff, dy3_ff;
   logic signed [DIFF_WIDTH-1:0] dx4_ff, dy4_ff;
   logic signed [2*DIFF_WIDTH-1:0] px, py;
   logic [D2_WIDTH-2:0]          sqx_ff, sqy_ff;
   logic [D2_WIDTH-1:0]          d2_ff;
   logic [ROOT1_WIDTH-1:0]       rad1_ff;
   status_type                   st4_in, st4_ff;
   logic signed [NUM_WIDTH-1:0]  nums4_ff, nume4_ff;

   assign px = dx1_ff * dx1_ff;
   assign py = dy1_ff * dy1_ff;

   always_comb begin
      if (d2_ff == '0) begin
         st4_in = ST_ZERO;
      end else if (lzero_ff || d2_ff > D2_WIDTH'(lsumsq_ff) ||
                   d2_ff < D2_WIDTH'(ldiffsq_ff)) begin
         st4_in = ST_REACH;
      end else begin
         st4_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff    <= req_tdata[15:0];
         ty_ff    <= req_tdata[31:16];
         dx1_ff   <= $signed({tx_ff[COORD_WIDTH-1], tx_ff}) -
                     $signed({base_x_ff[COORD_WIDTH-1], base_x_ff});
         dy1_ff   <= $signed({ty_ff[COORD_WIDTH-1], ty_ff}) -
                     $signed({base_y_ff[COORD_WIDTH-1], base_y_ff});
         sqx_ff   <= px[D2_WIDTH-2:0];
         sqy_ff   <= py[D2_WIDTH-2:0];
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         d2_ff    <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
         dx3_ff   <= dx2_ff;
         dy3_ff   <= dy2_ff;
         st4_ff   <= st4_in;
         // in reach the squared distance fits the root's width
         rad1_ff  <= d2_ff[ROOT1_WIDTH-1:0];
         nums4_ff <= $signed({2'b00, d2_ff}) + NUM_WIDTH'(lsub_ff);
         nume4_ff <= $signed({5'b00000, ladd_ff}) - $signed({2'b00, d2_ff});
         dx4_ff   <= dx3_ff;
         dy4_ff   <= dy3_ff;
      end
   end

   // side band carried alongside the arithmetic chains
   logic [DIFF_WIDTH-1:0] dx9, dy9;
   logic [1:0]            st_out;
   logic [NUM_WIDTH-1:0]  nums5, nume5;

   tlik_delay #(.WIDTH(DIFF_WIDTH), .DEPTH(SIDE_DEPTH)) u_dx_dly (
      .clock(clock), .en(en), .data_i(dx4_ff), .data_o(dx9));
   tlik_delay #(.WIDTH(DIFF_WIDTH), .DEPTH(SIDE_DEPTH)) u_dy_dly (
      .clock(clock), .en(en), .data_i(dy4_ff), .data_o(dy9));
   tlik_delay #(.WIDTH(2), .DEPTH(STATUS_DEPTH)) u_st_dly (
      .clock(clock), .en(en), .data_i(st4_ff), .data_o(st_out));
   tlik_delay #(.WIDTH(NUM_WIDTH), .DEPTH(NUM_DEPTH)) u_nums_dly (
      .clock(clock), .en(en), .data_i(nums4_ff), .data_o(nums5));
   tlik_delay #(.WIDTH(NUM_WIDTH), .DEPTH(NUM_DEPTH)) u_nume_dly (
      .clock(clock), .en(en), .data_i(nume4_ff), .data_o(nume5));

   // ------------------------------------------------------------------
   // distance: one root bit per cell
   // ------------------------------------------------------------------
   logic [ROOT1_WIDTH-1:0] sq1_rem [SQ1_STEPS+1];
   logic [ROOT1_WIDTH-1:0] sq1_root [SQ1_STEPS+1];

   assign sq1_rem[0]  = rad1_ff;
   assign sq1_root[0] = '0;

   for (genvar i = 0; i < SQ1_STEPS; i++) begin : g_sq1
      tlik_sqrt_cell #(.WIDTH(ROOT1_WIDTH), .K(SQ1_STEPS - 1 - i)) u_cell (
         .clock(clock), .en(en),
         .rem_i(sq1_rem[i]), .root_i(sq1_root[i]),
         .rem_o(sq1_rem[i+1]), .root_o(sq1_root[i+1]));
   end

   // ------------------------------------------------------------------
   // ratio set-up: denominators, rounded numerators, early overflow
   // ------------------------------------------------------------------
   logic [DEN_WIDTH-1:0]    dens5_ff, dens6_ff, dene6_ff;
   logic [2*LEN_WIDTH:0]    dprod;
   logic [NUM_WIDTH-1:0]    mags, mage;
   logic [REM_WIDTH-1:0]    ns, ne, ns6_ff, ne6_ff;
   logic [3:0]              flag6_ff, flag7;

   assign dprod = sq1_root[SQ1_STEPS][DIST_WIDTH-1:0] * l1_ff;
   assign mags  = nums5[NUM_WIDTH-1] ? -nums5 : nums5;
   assign mage  = nume5[NUM_WIDTH-1] ? -nume5 : nume5;
   assign ns    = {mags[REM_WIDTH-15:0], 14'b0} + REM_WIDTH'(dens5_ff >> 1);
   assign ne    = {mage[REM_WIDTH-15:0], 14'b0} + REM_WIDTH'(dene >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         dens5_ff <= {dprod, 1'b0};
         ns6_ff   <= ns;
         ne6_ff   <= ne;
         dens6_ff <= dens5_ff;
         dene6_ff <= dene;
         // {shoulder negative, shoulder saturates, elbow negative, elbow saturates}
         flag6_ff <= {nums5[NUM_WIDTH-1], ns >= {dens5_ff, 16'b0},
                      nume5[NUM_WIDTH-1], ne >= {dene, 16'b0}};
      end
   end

   tlik_delay #(.WIDTH(4), .DEPTH(DIV_STEPS)) u_flag_dly (
      .clock(clock), .en(en), .data_i(flag6_ff), .data_o(flag7));

   // ------------------------------------------------------------------
   // the two cosine ratios: one quotient bit per cell
   // ------------------------------------------------------------------
   logic [REM_WIDTH-1:0] dvs_rem [DIV_STEPS+1], dve_rem [DIV_STEPS+1];
   logic [DEN_WIDTH-1:0] dvs_den [DIV_STEPS+1], dve_den [DIV_STEPS+1];
   logic [QUO_WIDTH-1:0] dvs_quo [DIV_STEPS+1], dve_quo [DIV_STEPS+1];

   assign dvs_rem[0] = ns6_ff;
   assign dvs_den[0] = dens6_ff;
   assign dvs_quo[0] = '0;
   assign dve_rem[0] = ne6_ff;
   assign dve_den[0] = dene6_ff;
   assign dve_quo[0] = '0;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      tlik_div_cell #(.K(DIV_STEPS - 1 - i)) u_shoulder (
         .clock(clock), .en(en),
         .rem_i(dvs_rem[i]), .den_i(dvs_den[i]), .quo_i(dvs_quo[i]),
         .rem_o(dvs_rem[i+1]), .den_o(dvs_den[i+1]), .quo_o(dvs_quo[i+1]));
      tlik_div_cell #(.K(DIV_STEPS - 1 - i)) u_elbow (
         .clock(clock), .en(en),
         .rem_i(dve_rem[i]), .den_i(dve_den[i]), .quo_i(dve_quo[i]),
         .rem_o(dve_rem[i+1]), .den_o(dve_den[i+1]), .quo_o(dve_quo[i+1]));
   end

   // ------------------------------------------------------------------
   // clamp to [-1, 1], then sine magnitude radicand 1 - c^2
   // ------------------------------------------------------------------
   logic [MAG_WIDTH-1:0]   mags7_ff, mage7_ff;
   logic                   negs7_ff, nege7_ff;
   logic [ROOT2_WIDTH-1:0] csqs, csqe, rads8_ff, rade8_ff;
   logic signed [MAG_WIDTH:0] cs8_ff, ce8_ff;
   logic [MAG_WIDTH:0]     cs9, ce9;

   assign csqs = mags7_ff * mags7_ff;
   assign csqe = mage7_ff * mage7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mags7_ff <= (flag7[2] || dvs_quo[DIV_STEPS] > QUO_WIDTH'(ONE_Q14)) ?
                     MAG_WIDTH'(ONE_Q14) : dvs_quo[DIV_STEPS][MAG_WIDTH-1:0];
         mage7_ff <= (flag7[0] || dve_quo[DIV_STEPS] > QUO_WIDTH'(ONE_Q14)) ?
                     MAG_WIDTH'(ONE_Q14) : dve_quo[DIV_STEPS][MAG_WIDTH-1:0];
         negs7_ff <= flag7[3];
         nege7_ff <= flag7[1];
         rads8_ff <= ONE_SQ - csqs;
         rade8_ff <= ONE_SQ - csqe;
         cs8_ff   <= negs7_ff ? -$signed({1'b0, mags7_ff}) : $signed({1'b0, mags7_ff});
         ce8_ff   <= nege7_ff ? -$signed({1'b0, mage7_ff}) : $signed({1'b0, mage7_ff});
      end
   end

   tlik_delay #(.WIDTH(MAG_WIDTH + 1), .DEPTH(SQ2_STEPS)) u_cs_dly (
      .clock(clock), .en(en), .data_i(cs8_ff), .data_o(cs9));
   tlik_delay #(.WIDTH(MAG_WIDTH + 1), .DEPTH(SQ2_STEPS)) u_ce_dly (
      .clock(clock), .en(en), .data_i(ce8_ff), .data_o(ce9));

   logic [ROOT2_WIDTH-1:0] sqs_rem [SQ2_STEPS+1], sqs_root [SQ2_STEPS+1];
   logic [ROOT2_WIDTH-1:0] sqe_rem [SQ2_STEPS+1], sqe_root [SQ2_STEPS+1];

   assign sqs_rem[0]  = rads8_ff;
   assign sqs_root[0] = '0;
   assign sqe_rem[0]  = rade8_ff;
   assign sqe_root[0] = '0;

   for (genvar i = 0; i < SQ2_STEPS; i++) begin : g_sq2
      tlik_sqrt_cell #(.WIDTH(ROOT2_WIDTH), .K(SQ2_STEPS - 1 - i)) u_shoulder (
         .clock(clock), .en(en),
         .rem_i(sqs_rem[i]), .root_i(sqs_root[i]),
         .rem_o(sqs_rem[i+1]), .root_o(sqs_root[i+1]));
      tlik_sqrt_cell #(.WIDTH(ROOT2_WIDTH), .K(SQ2_STEPS - 1 - i)) u_elbow (
         .clock(clock), .en(en),
         .rem_i(sqe_rem[i]), .root_i(sqe_root[i]),
         .rem_o(sqe_rem[i+1]), .root_o(sqe_root[i+1]));
   end

   // ------------------------------------------------------------------
   // three vectoring chains: bearing, shoulder acos, elbow acos
   // ------------------------------------------------------------------
   function automatic vec_type prerotate(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
      vec_type v;
      v.x = x;
      v.y = y;
      v.z = '0;
      // fold the left half-plane over by a quarter turn
      if (x < 0) begin
         if (y >= 0) begin
            v.x = y;
            v.y = -x;
            v.z = ZW'(HALF_PI_Q28);
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -ZW'(HALF_PI_Q28);
         end
      end
      return v;
   endfunction

   logic signed [CW-1:0] bx, by, sx, sy, ex, ey;
   vec_type vb [CORDIC_STEPS+1], vs [CORDIC_STEPS+1], ve [CORDIC_STEPS+1];
   vec_type vb9_ff, vs9_ff, ve9_ff;

   assign bx = CW'($signed(dx9)) <<< 20;
   assign by = CW'($signed(dy9)) <<< 20;
   assign sx = CW'($signed(cs9)) <<< 24;
   assign sy = CW'(sqs_root[SQ2_STEPS][MAG_WIDTH-1:0]) <<< 24;
   assign ex = CW'($signed(ce9)) <<< 24;
   assign ey = CW'(sqe_root[SQ2_STEPS][MAG_WIDTH-1:0]) <<< 24;

   always_ff @(posedge clock) begin
      if (en) begin
         vb9_ff <= prerotate(bx, by);
         vs9_ff <= prerotate(sx, sy);
         ve9_ff <= prerotate(ex, ey);
      end
   end

   assign vb[0] = vb9_ff;
   assign vs[0] = vs9_ff;
   assign ve[0] = ve9_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      tlik_cordic_cell #(.K(i)) u_bearing (
         .clock(clock), .en(en), .vec_i(vb[i]), .vec_o(vb[i+1]));
      tlik_cordic_cell #(.K(i)) u_shoulder (
         .clock(clock), .en(en), .vec_i(vs[i]), .vec_o(vs[i+1]));
      tlik_cordic_cell #(.K(i)) u_elbow (
         .clock(clock), .en(en), .vec_i(ve[i]), .vec_o(ve[i+1]));
   end

   // ------------------------------------------------------------------
   // output register: round Q3.28 to Q3.12, clamp the elbow, apply status
   // ------------------------------------------------------------------
   function automatic logic signed [33:0] round_q12(input logic signed [33:0] z);
      logic signed [33:0] m;
      m = -z;
      if (z >= 0) begin
         return (z + 34'sd32768) >>> 16;
      end
      return -((m + 34'sd32768) >>> 16);
   endfunction

   logic signed [33:0]     zup, rup, rel;
   logic [ELBOW_WIDTH-1:0] el;
   logic [31:0]            rsp_tdata_ff;
   logic [1:0]             rsp_tuser_ff;

   assign zup = 34'(vb[CORDIC_STEPS].z) + 34'(vs[CORDIC_STEPS].z);
   assign rup = round_q12(zup);
   assign rel = round_q12(34'(ve[CORDIC_STEPS].z));

   always_comb begin
      if (rel < 0) begin
         el = '0;
      end else if (rel > 34'sd12868) begin
         el = ELBOW_WIDTH'(PI_Q12);
      end else begin
         el = rel[ELBOW_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tuser_ff <= st_out;
         if (status_type'(st_out) == ST_OK) begin
            rsp_tdata_ff <= {2'b00, el, rup[ANGLE_WIDTH-1:0]};
         end else begin
            rsp_tdata_ff <= '0;
         end
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

endmodule

`default_nettype wire

### rtl/core/tlik_checker.sv
`default_nettype none

module tlik_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   import tlik_pkg::*;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

   // failed targets carry zero angles
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0)
      else $error("angles not zero on failed target");

   // elbow stays within zero to pi
   a_elbow_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:16] <= 14'(PI_Q12) && rsp_tdata[31:30] == 2'b00)
      else $error("elbow angle out of range");

   // drop all results on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind two_link_inverse_kinematics_unit tlik_checker u_tlik_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;
   import tlik_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS      = 16;
   localparam int IDLE_LIMIT = 4000;   // cycles without any beat before giving up
   localparam int DRAIN_WAIT = 90;     // pipeline is 58 + STEPS deep
   localparam int N_PHASES   = 8;
   localparam int PER_PHASE  = 225;
   localparam int QUIET_TAIL = 150;    // last beats of the run go through without idling

   localparam longint HALF_PI_L = 421657428;
   localparam longint ONE_L     = 16384;

   typedef struct {
      logic [15:0] upper;
      logic [13:0] elbow;
      status_type  status;
   } arm_angles_type;

   typedef struct {
      logic signed [15:0] tx;
      logic signed [15:0] ty;
      bit                 typed;   // expectation written in the row itself
      arm_angles_type     want;
   } target_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // shadow of the register file
   logic signed [15:0] arm_base_x, arm_base_y;
   logic [14:0]        arm_len_upper, arm_len_lower;

   arm_angles_type pending_angles[$];
   int             mismatch_count = 0;
   bit             failed = 1'b0;
   bit             quiet = 1'b0;
   int             idle_cycles = 0;

   two_link_inverse_kinematics_unit #(.CORDIC_STEPS(STEPS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   // vectoring rotation, angle in Q3.28; shifts floor toward minus infinity
   function automatic longint bearing_q28(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;  y = -t; z = HALF_PI_L;
         end else begin
            x = -y; y = t;  z = -HALF_PI_L;
         end
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y < 0) begin
            x = x - ys; y = y + xs; z -= ATAN_Q28[i];
         end else begin
            x = x + ys; y = y - xs; z += ATAN_Q28[i];
         end
      end
      return z;
   endfunction

   function automatic longint arccos_q28(longint c);
      longint s;
      s = floor_sqrt(longint'(ONE_L * ONE_L - c * c));
      return bearing_q28(s * 64'd16777216, c * 64'd16777216);
   endfunction

   // Q2.14 quotient, half away from zero, held to [-1, 1]
   function automatic longint cosine_q14(longint num, longint den);
      longint m, q;
      m = (num < 0) ? -num : num;
      q = ((m << 14) + den / 2) / den;
      if (q > ONE_L) q = ONE_L;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint to_q12(longint z);
      if (z >= 0) return (z + 32768) >>> 16;
      return -(((-z) + 32768) >>> 16);
   endfunction

   function automatic arm_angles_type solve_arm(logic signed [15:0] tx,
                                                logic signed [15:0] ty);
      arm_angles_type a;
      longint dx, dy, l1, l2, d2, reach, cs, ce, up, el;
      dx = longint'(tx) - longint'(arm_base_x);
      dy = longint'(ty) - longint'(arm_base_y);
      l1 = longint'(arm_len_upper);
      l2 = longint'(arm_len_lower);
      d2 = dx * dx + dy * dy;
      up = 0;
      el = 0;
      a.status = ST_OK;
      if (d2 == 0) begin
         a.status = ST_ZERO;
      end else if (l1 == 0 || l2 == 0 || d2 > (l1 + l2) * (l1 + l2)
                   || d2 < (l1 - l2) * (l1 - l2)) begin
         a.status = ST_REACH;
      end else begin
         reach = floor_sqrt(d2);
         cs = cosine_q14(d2 + l1 * l1 - l2 * l2, 2 * reach * l1);
         ce = cosine_q14(l1 * l1 + l2 * l2 - d2, 2 * l1 * l2);
         up = to_q12(bearing_q28(dy * 64'd1048576, dx * 64'd1048576) + arccos_q28(cs));
         el = to_q12(arccos_q28(ce));
         if (el < 0) el = 0;
         if (el > PI_Q12) el = PI_Q12;
      end
      a.upper = up[15:0];
      a.elbow = el[13:0];
      return a;
   endfunction

   // ---------------------------------------------------------------- monitor

   // predict on every request beat, check every response beat against the oldest
   always @(posedge clock) begin
      arm_angles_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready)
            pending_angles.push_back(solve_arm(req_tdata[15:0], req_tdata[31:16]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_angles.size() == 0) begin
               failed = 1'b1;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response beat: tdata=%h tuser=%0d", rsp_tdata, rsp_tuser);
            end else begin
               want = pending_angles.pop_front();
               if (rsp_tdata[15:0] !== want.upper || rsp_tdata[29:16] !== want.elbow
                   || rsp_tuser !== want.status) begin
                  failed = 1'b1;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: upper %h/%h elbow %0d/%0d status %0d/%0d (exp/got)",
                              want.upper, rsp_tdata[15:0], want.elbow, rsp_tdata[29:16],
                              want.status, rsp_tuser);
               end
            end
         end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side: stall in bursts, none once the run is in its tail
   initial begin
      int stall_odds;
      stall_odds = 4;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) == 0) stall_odds = $urandom_range(0, 8);
         if (!quiet && stall_odds != 0 && $urandom_range(0, 9) < stall_odds) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_BASE_X:    arm_base_x    = value;
         REG_BASE_Y:    arm_base_y    = value;
         REG_UPPER_LEN: arm_len_upper = value[14:0];
         REG_LOWER_LEN: arm_len_lower = value[14:0];
      endcase
   endtask

   // hold off until every response is back, then let the pipe empty
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic send_target(logic [15:0] tx, logic [15:0] ty);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ty, tx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mostly targets in a square around the reachable ring, some anywhere
   task automatic random_target(output logic [15:0] tx, output logic [15:0] ty);
      int span;
      span = int'(arm_len_upper) + int'(arm_len_lower) + 2;
      if ($urandom_range(0, 3) != 0) begin
         tx = arm_base_x + 16'($signed($urandom_range(0, 2 * span)) - span);
         ty = arm_base_y + 16'($signed($urandom_range(0, 2 * span)) - span);
      end else begin
         tx = $urandom;
         ty = $urandom;
      end
   endtask

   target_row_type directed[$];

   initial begin
      logic [15:0] tx, ty;
      logic [15:0] cfg [4];
      int remaining;
      arm_base_x    = 16'sd0;
      arm_base_y    = 16'sd0;
      arm_len_upper = 15'd256;
      arm_len_lower = 15'd256;

      // reset state: base at origin, both links 1.0
      directed = '{
         '{16'sd0,      16'sd0,      1, '{16'd0, 14'd0, ST_ZERO}},   // target on the base
         '{16'sh7fff,   16'sh7fff,   1, '{16'd0, 14'd0, ST_REACH}},
         '{16'sh8000,   16'sh8000,   1, '{16'd0, 14'd0, ST_REACH}},
         '{16'sh8000,   16'sh7fff,   1, '{16'd0, 14'd0, ST_REACH}},
         '{16'sd513,    16'sd0,      1, '{16'd0, 14'd0, ST_REACH}},  // just past full stretch
         '{16'sd512,    16'sd0,      0, '{16'd0, 14'd0, ST_OK}},     // full stretch
         '{-16'sd512,   16'sd0,      0, '{16'd0, 14'd0, ST_OK}},
         '{16'sd0,      16'sd512,    0, '{16'd0, 14'd0, ST_OK}},
         '{16'sd0,      -16'sd512,   0, '{16'd0, 14'd0, ST_OK}},
         '{-16'sd300,   -16'sd200,   0, '{16'd0, 14'd0, ST_OK}},
         '{-16'sd300,   16'sd200,    0, '{16'd0, 14'd0, ST_OK}},
         '{16'sd1,      16'sd0,      0, '{16'd0, 14'd0, ST_OK}},     // folded elbow
         '{16'sd0,      -16'sd1,     0, '{16'd0, 14'd0, ST_OK}},
         '{16'sd362,    16'sd362,    0, '{16'd0, 14'd0, ST_OK}},
         '{16'sd200,    -16'sd100,   0, '{16'd0, 14'd0, ST_OK}}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the table; typed rows are checked against the row, all against the model
      foreach (directed[i]) begin
         send_target(directed[i].tx, directed[i].ty);
         if (directed[i].typed) begin
            arm_angles_type got;
            got = solve_arm(directed[i].tx, directed[i].ty);
            if (got.upper != directed[i].want.upper || got.elbow != directed[i].want.elbow
                || got.status != directed[i].want.status) begin
               failed = 1'b1;
               $display("table row %0d disagrees with prediction", i);
            end
         end
      end
      drain();

      remaining = N_PHASES * PER_PHASE;
      for (int phase = 0; phase < N_PHASES; phase++) begin
         case (phase)
            0: cfg = '{16'h0000, 16'h0000, 16'h0100, 16'h0100};
            1: cfg = '{16'h8000, 16'h7fff, 16'hffff, 16'h7fff};  // extremes, bit 15 masked
            2: cfg = '{16'h7fff, 16'h8000, 16'h0000, 16'h0200};  // upper link of zero length
            3: cfg = '{16'h0123, 16'hfedc, 16'h0300, 16'h0000};  // lower link of zero length
            4: cfg = '{16'h0000, 16'h0000, 16'h0400, 16'h0100};  // unequal links: a hole
            default: cfg = '{16'($urandom), 16'($urandom),
                             16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000))};
         endcase
         write_reg(REG_BASE_X, cfg[0]);
         write_reg(REG_BASE_Y, cfg[1]);
         write_reg(REG_UPPER_LEN, cfg[2]);
         write_reg(REG_LOWER_LEN, cfg[3]);
         send_target(arm_base_x, arm_base_y);   // zero distance under this setting
         for (int k = 0; k < PER_PHASE; k++) begin
            remaining--;
            quiet = (remaining < QUIET_TAIL);
            random_target(tx, ty);
            send_target(tx, ty);
         end
         drain();
      end

      if (pending_angles.size() != 0) failed = 1'b1;
      if (!failed && mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
